// ----- hdl/radix2_fft_ifft_macros.svh -----
// ---------------------------------------------------------------------------
// radix2_fft_ifft assertion macros
// Shared concurrent assertion forms for the FFT block.
// ---------------------------------------------------------------------------
`ifndef RADIX2_FFT_IFFT_MACROS_SVH
`define RADIX2_FFT_IFFT_MACROS_SVH

// same-cycle implication under the block reset
`define R2F_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under the block reset
`define R2F_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/r2f_pkg.sv -----
// ---------------------------------------------------------------------------
// r2f_pkg
// Shared widths, twiddle ROM and controller command type for the FFT.
// ---------------------------------------------------------------------------
package r2f_pkg;

  localparam int DefMaxPoints = 64;
  localparam int SampleW      = 16;
  localparam int WordW        = 22;
  localparam int BinIdxW      = 6;
  localparam int LogW         = 3;
  localparam int TwW          = 16;
  localparam int ProdW        = WordW + TwW;

  // configuration register indices
  localparam logic [1:0] CfgInverse = 2'd0;
  localparam logic [1:0] CfgSize    = 2'd1;

  // quarter wave of cos(pi*m/32), m = 0 saturated
  localparam logic signed [TwW-1:0] QuarterCos [17] = '{
    16'sd32767, 16'sd32610, 16'sd32138, 16'sd31357, 16'sd30274, 16'sd28899,
    16'sd27246, 16'sd25330, 16'sd23170, 16'sd20788, 16'sd18205, 16'sd15447,
    16'sd12540, 16'sd9512,  16'sd6393,  16'sd3212,  16'sd0
  };

  typedef struct packed {
    logic signed [TwW-1:0] re;
    logic signed [TwW-1:0] im;
  } twiddle_t;

  // controller to datapath strobes
  typedef struct packed {
    logic load_we;
    logic rd_en;
    logic mul_en;
    logic add_en;
    logic wr_a;
    logic wr_b;
    logic out_rd;
    logic out_load;
    logic first_stage;
    logic inv;
    logic last;
  } cmd_t;

  // floor(log2(points)), at least one and at most six
  function automatic int max_log(input int points);
    int l;
    l = 0;
    while ((l < 6) && ((2 << l) <= points)) l++;
    if (l < 1) l = 1;
    return l;
  endfunction

  // exp(-j*2*pi*k/64) for k in 0..31
  function automatic twiddle_t twiddle(input logic [4:0] k);
    twiddle_t w;
    if (k <= 5'd16) begin
      w.re = QuarterCos[k];
      w.im = -QuarterCos[5'd16 - k];
    end else begin
      w.re = -QuarterCos[5'(6'd32 - {1'b0, k})];
      w.im = -QuarterCos[k - 5'd16];
    end
    return w;
  endfunction

endpackage

// ----- hdl/radix2_fft_ifft.sv -----
// ---------------------------------------------------------------------------
// radix2_fft_ifft
// Frame radix-2 DIT FFT / scaled IFFT with a single shared butterfly.
// ---------------------------------------------------------------------------
// Usage:
//   Samples enter on s_axis (tdata = re, im), one per request, until
//   n = 2^size_log2 have arrived (size clamped to 1 .. log2 MAX_POINTS).
//   The frame is then transformed in place and n bins leave on m_axis in
//   bin order, tlast on the final bin. Config writes (index 0 inverse
//   mode, index 1 size_log2) are always accepted; write them between frames.
//   Loading accepts one sample per cycle while valid; the transform runs
//   (n/2)*log2(n) butterflies one at a time, each through read, multiply,
//   add, write A and write B on the single butterfly unit and work RAM
//   write port; each bin is read, loaded and held valid until taken.
//   s_axis is not ready while a frame is transformed or unloaded.
//   A stalled receiver holds the current bin and pauses the unload.
//   Reset clears the control state and the registers (forward, size 6);
//   the sample store holds no defined data until loaded.
// ---------------------------------------------------------------------------
module radix2_fft_ifft #(
  parameter int MAX_POINTS = r2f_pkg::DefMaxPoints
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] sample_re, [31:16] sample_im
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [21:0] bin_re, [43:22] bin_im, [49:44] bin_index
  output logic        m_axis_tlast,   // last_bin
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [2:0]  cfg_data_i
);
  import r2f_pkg::*;

  localparam int AddrW = max_log(MAX_POINTS);

  logic            inv_cfg_q;
  logic [LogW-1:0] size_cfg_q, eff_lg;
  cmd_t            cmd;
  logic [AddrW-1:0] load_addr, bf_idx, out_idx;
  logic [LogW-1:0] stage, lg;
  logic signed [WordW-1:0] bin_re, bin_im;
  logic [BinIdxW-1:0] bin_index;
  logic            last_take;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_cfg_q  <= 1'b0;
      size_cfg_q <= LogW'(6);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgInverse) inv_cfg_q <= cfg_data_i[0];
      if (cfg_index_i == CfgSize) size_cfg_q <= cfg_data_i;
    end
  end

  // clamp length to the supported range
  always_comb begin
    eff_lg = size_cfg_q;
    if (eff_lg < LogW'(1)) eff_lg = LogW'(1);
    if (eff_lg > LogW'(AddrW)) eff_lg = LogW'(AddrW);
  end

  r2f_ctrl #(.MAX_POINTS(MAX_POINTS), .AddrW(AddrW)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cfg_inv_i   (inv_cfg_q),
    .cfg_lg_i    (eff_lg),
    .cmd_o       (cmd),
    .load_addr_o (load_addr),
    .bf_idx_o    (bf_idx),
    .out_idx_o   (out_idx),
    .stage_o     (stage),
    .lg_o        (lg)
  );

  r2f_datapath #(.MAX_POINTS(MAX_POINTS), .AddrW(AddrW)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .load_addr_i (load_addr),
    .bf_idx_i    (bf_idx),
    .out_idx_i   (out_idx),
    .stage_i     (stage),
    .lg_i        (lg),
    .sample_re_i (s_axis_tdata[15:0]),
    .sample_im_i (s_axis_tdata[31:16]),
    .bin_re_o    (bin_re),
    .bin_im_o    (bin_im),
    .bin_index_o (bin_index),
    .last_bin_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, bin_index, bin_im, bin_re};

  // checks
  assign last_take = m_axis_tvalid && m_axis_tready && m_axis_tlast;

`include "radix2_fft_ifft_macros.svh"

  `R2F_ASSERT_NOW(a_no_overlap, m_axis_tvalid, !s_axis_tready, "load overlaps unload")
  `R2F_ASSERT_NEXT(a_last_to_load, last_take, s_axis_tready && !m_axis_tvalid, "no reload")

endmodule

// ----- hdl/r2f_datapath.sv -----
// ---------------------------------------------------------------------------
// r2f_datapath
// Sample store, work RAM, shared butterfly and output scaling register.
// ---------------------------------------------------------------------------
module r2f_datapath #(
  parameter int MAX_POINTS = r2f_pkg::DefMaxPoints,
  parameter int AddrW      = r2f_pkg::max_log(MAX_POINTS)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  r2f_pkg::cmd_t                       cmd_i,
  input  logic [AddrW-1:0]                    load_addr_i,
  input  logic [AddrW-1:0]                    bf_idx_i,
  input  logic [AddrW-1:0]                    out_idx_i,
  input  logic [r2f_pkg::LogW-1:0]            stage_i,
  input  logic [r2f_pkg::LogW-1:0]            lg_i,
  input  logic signed [r2f_pkg::SampleW-1:0]  sample_re_i,
  input  logic signed [r2f_pkg::SampleW-1:0]  sample_im_i,
  output logic signed [r2f_pkg::WordW-1:0]    bin_re_o,
  output logic signed [r2f_pkg::WordW-1:0]    bin_im_o,
  output logic [r2f_pkg::BinIdxW-1:0]         bin_index_o,
  output logic                                last_bin_o
);
  import r2f_pkg::*;

  localparam int Depth = 1 << AddrW;

  logic signed [SampleW-1:0] st_re [Depth];
  logic signed [SampleW-1:0] st_im [Depth];
  logic [2*WordW-1:0]        work  [Depth];

  logic [AddrW-1:0] lo_mask, lo, addr_a, addr_b, rev_a, rev_b, wr_addr;
  logic [2*WordW-1:0] wr_data;
  twiddle_t tw;
  logic [4:0] tw_idx;

  logic signed [WordW-1:0] ea_re_q, ea_im_q, ob_re_q, ob_im_q;
  logic signed [ProdW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [ProdW+1:0] sum_re, sum_im;
  logic signed [WordW-1:0] t_re_q, t_im_q;
  logic [2*WordW-1:0]      od_q;
  logic signed [WordW+1:0] sc_re, sc_im, bias;

  function automatic logic [AddrW-1:0] bit_rev(input logic [AddrW-1:0] v,
                                               input logic [LogW-1:0] l);
    logic [AddrW-1:0] r;
    for (int i = 0; i < AddrW; i++) r[i] = v[AddrW-1-i];
    return r >> (LogW'(AddrW) - l);
  endfunction

  // butterfly pair addresses for this stage
  always_comb begin
    lo_mask = (AddrW'(1) << (stage_i - 1'b1)) - 1'b1;
    lo      = bf_idx_i & lo_mask;
    addr_a  = ((bf_idx_i & ~lo_mask) << 1) | lo;
    addr_b  = addr_a | (lo_mask + 1'b1);
    rev_a   = bit_rev(addr_a, lg_i);
    rev_b   = bit_rev(addr_b, lg_i);
    tw_idx  = 5'(6'(lo) << (LogW'(6) - stage_i));
    tw      = twiddle(tw_idx);
  end

  // sample store: loaded in arrival order
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      st_re[load_addr_i] <= sample_re_i;
      st_im[load_addr_i] <= sample_im_i;
    end
  end

  // operand fetch; first stage reads the store in bit-reversed order
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      if (cmd_i.first_stage) begin
        ea_re_q <= WordW'(st_re[rev_a]);
        ob_re_q <= WordW'(st_re[rev_b]);
        ea_im_q <= cmd_i.inv ? -WordW'(st_im[rev_a]) : WordW'(st_im[rev_a]);
        ob_im_q <= cmd_i.inv ? -WordW'(st_im[rev_b]) : WordW'(st_im[rev_b]);
      end else begin
        ea_re_q <= work[addr_a][WordW-1:0];
        ea_im_q <= work[addr_a][2*WordW-1:WordW];
        ob_re_q <= work[addr_b][WordW-1:0];
        ob_im_q <= work[addr_b][2*WordW-1:WordW];
      end
    end
  end

  // twiddle products
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      p_rr_q <= ob_re_q * tw.re;
      p_ii_q <= ob_im_q * tw.im;
      p_ri_q <= ob_re_q * tw.im;
      p_ir_q <= ob_im_q * tw.re;
    end
  end

  // round products back to Q.15
  assign sum_re = (ProdW+2)'(p_rr_q) - (ProdW+2)'(p_ii_q) + (ProdW+2)'(16384);
  assign sum_im = (ProdW+2)'(p_ri_q) + (ProdW+2)'(p_ir_q) + (ProdW+2)'(16384);

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_en) begin
      t_re_q <= sum_re[WordW+14:15];
      t_im_q <= sum_im[WordW+14:15];
    end
  end

  // work RAM write: sum then difference, wrapping to the word width
  always_comb begin
    wr_addr = cmd_i.wr_a ? addr_a : addr_b;
    wr_data = cmd_i.wr_a ? {ea_im_q + t_im_q, ea_re_q + t_re_q}
                         : {ea_im_q - t_im_q, ea_re_q - t_re_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a || cmd_i.wr_b) work[wr_addr] <= wr_data;
    if (cmd_i.out_rd) od_q <= work[out_idx_i];
  end

  // inverse: conjugate and rounding shift by log2 n
  always_comb begin
    bias  = (WordW+2)'(1) << (lg_i - 1'b1);
    sc_re = ((WordW+2)'(signed'(od_q[WordW-1:0])) + bias) >>> lg_i;
    sc_im = (-(WordW+2)'(signed'(od_q[2*WordW-1:WordW])) + bias) >>> lg_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_re_o    <= '0;
      bin_im_o    <= '0;
      bin_index_o <= '0;
      last_bin_o  <= 1'b0;
    end else if (cmd_i.out_load) begin
      bin_re_o    <= cmd_i.inv ? sc_re[WordW-1:0] : od_q[WordW-1:0];
      bin_im_o    <= cmd_i.inv ? sc_im[WordW-1:0] : od_q[2*WordW-1:WordW];
      bin_index_o <= BinIdxW'(out_idx_i);
      last_bin_o  <= cmd_i.last;
    end
  end

endmodule

// ----- hdl/r2f_ctrl.sv -----
// ---------------------------------------------------------------------------
// r2f_ctrl
// Frame sequencer: load, butterfly passes over the work RAM, unload.
// ---------------------------------------------------------------------------
module r2f_ctrl #(
  parameter int MAX_POINTS = r2f_pkg::DefMaxPoints,
  parameter int AddrW      = r2f_pkg::max_log(MAX_POINTS)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  input  logic                       cfg_inv_i,
  input  logic [r2f_pkg::LogW-1:0]   cfg_lg_i,
  output r2f_pkg::cmd_t              cmd_o,
  output logic [AddrW-1:0]           load_addr_o,
  output logic [AddrW-1:0]           bf_idx_o,
  output logic [AddrW-1:0]           out_idx_o,
  output logic [r2f_pkg::LogW-1:0]   stage_o,
  output logic [r2f_pkg::LogW-1:0]   lg_o
);
  import r2f_pkg::*;

  localparam logic [3:0] StLoad   = 4'd0;
  localparam logic [3:0] StRead   = 4'd1;
  localparam logic [3:0] StMul    = 4'd2;
  localparam logic [3:0] StAdd    = 4'd3;
  localparam logic [3:0] StWrA    = 4'd4;
  localparam logic [3:0] StWrB    = 4'd5;
  localparam logic [3:0] StOutRd  = 4'd6;
  localparam logic [3:0] StOutLd  = 4'd7;
  localparam logic [3:0] StOutVal = 4'd8;

  logic [3:0]      state_q, state_d;
  logic [AddrW:0]  cnt_q, cnt_d, cnt_inc;
  logic [LogW-1:0] lg_q, lg_d, stage_q, stage_d;
  logic            inv_q, inv_d;
  logic [AddrW-1:0] j_q, j_d, i_q, i_d, j_last, i_last;
  logic            frame_done;

  assign cnt_inc    = cnt_q + 1'b1;
  assign frame_done = cnt_inc >= ((AddrW+1)'(1) << cfg_lg_i);
  assign j_last     = (AddrW'(1) << (lg_q - 1'b1)) - 1'b1;
  assign i_last     = AddrW'(((AddrW+1)'(1) << lg_q) - 1'b1);

  // next state and counters
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    lg_d    = lg_q;
    inv_d   = inv_q;
    stage_d = stage_q;
    j_d     = j_q;
    i_d     = i_q;
    case (state_q)
      StLoad: begin
        if (in_valid_i) begin
          cnt_d = cnt_inc;
          if (frame_done) begin
            cnt_d   = '0;
            lg_d    = cfg_lg_i;
            inv_d   = cfg_inv_i;
            stage_d = LogW'(1);
            j_d     = '0;
            state_d = StRead;
          end
        end
      end
      StRead:  state_d = StMul;
      StMul:   state_d = StAdd;
      StAdd:   state_d = StWrA;
      StWrA:   state_d = StWrB;
      StWrB: begin
        state_d = StRead;
        if (j_q == j_last) begin
          j_d = '0;
          if (stage_q == lg_q) begin
            i_d     = '0;
            state_d = StOutRd;
          end else begin
            stage_d = stage_q + 1'b1;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      StOutRd: state_d = StOutLd;
      StOutLd: state_d = StOutVal;
      StOutVal: begin
        if (out_ready_i) begin
          if (i_q == i_last) begin
            state_d = StLoad;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = StOutRd;
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_q   <= '0;
      lg_q    <= LogW'(1);
      inv_q   <= 1'b0;
      stage_q <= LogW'(1);
      j_q     <= '0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      lg_q    <= lg_d;
      inv_q   <= inv_d;
      stage_q <= stage_d;
      j_q     <= j_d;
      i_q     <= i_d;
    end
  end

  // command decode
  always_comb begin
    cmd_o             = '0;
    cmd_o.load_we     = (state_q == StLoad) && in_valid_i;
    cmd_o.rd_en       = (state_q == StRead);
    cmd_o.mul_en      = (state_q == StMul);
    cmd_o.add_en      = (state_q == StAdd);
    cmd_o.wr_a        = (state_q == StWrA);
    cmd_o.wr_b        = (state_q == StWrB);
    cmd_o.out_rd      = (state_q == StOutRd);
    cmd_o.out_load    = (state_q == StOutLd);
    cmd_o.first_stage = (stage_q == LogW'(1));
    cmd_o.inv         = inv_q;
    cmd_o.last        = (i_q == i_last);
  end

  assign in_ready_o  = (state_q == StLoad);
  assign out_valid_o = (state_q == StOutVal);
  assign load_addr_o = cnt_q[AddrW-1:0];
  assign bf_idx_o    = j_q;
  assign out_idx_o   = i_q;
  assign stage_o     = stage_q;
  assign lg_o        = lg_q;

endmodule
